/* hdl/xpmd_pkg.sv */
package xpmd_pkg;

  localparam int MaxColors   = 256;
  localparam int MaxKeyChars = 4;
  localparam int MaxWidth    = 4096;
  localparam int MaxHeight   = 4096;

  localparam int KeyW   = MaxKeyChars * 8;
  localparam int AddrW  = $clog2(MaxColors);
  localparam int CntW   = AddrW + 1;
  localparam int DimW   = 13;
  localparam int ColorW = 24;
  localparam int KlenW  = 4;
  localparam int TchW   = 7;

  localparam logic [31:0] NumCap = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    CMD_CHAR, CMD_EOL, CMD_EOD, CMD_NOP
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_HEADER, KIND_PIXEL, KIND_DONE, KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_HEADER, ERR_OVERSIZE, ERR_SHORT_COLOR, ERR_COLOR_SPEC, ERR_SHORT_ROW, ERR_EARLY_END
  } err_e;

  typedef enum logic [1:0] {
    PH_HEADER, PH_COLORS, PH_PIXELS, PH_WAIT
  } phase_e;

  typedef enum logic [2:0] {
    HS_SKIP, HS_SIGNP, HS_SIGNN, HS_DIGP, HS_DIGN, HS_FAIL, HS_DONE
  } hdr_state_e;

  typedef enum logic [2:0] {
    CS_KEY, CS_SEEK, CS_SKIP, CS_CAND, CS_AFTER, CS_TOK, CS_REST
  } col_state_e;

  typedef enum logic {
    SQ_IDLE, SQ_SEARCH
  } seq_e;

  typedef enum logic [1:0] {
    SR_IDLE, SR_READ, SR_CMP
  } srch_e;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  addr;
    logic [KeyW-1:0]   key;
    logic [ColorW-1:0] color;
  } tbl_wr_t;

  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] key;
    logic [CntW-1:0] count;
  } srch_req_t;

  typedef struct packed {
    logic              done;
    logic [ColorW-1:0] color;
  } srch_rsp_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] none_char(input logic [1:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (pos)
      2'd0: r = 8'h4e;
      2'd1: r = 8'h6f;
      2'd2: r = 8'h6e;
      default: r = 8'h65;
    endcase
    return r;
  endfunction

endpackage

/* hdl/xpmd_if.sv */
interface xpmd_in_if import xpmd_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] byte_req;

  modport source (output valid, output cmd, output byte_req, input ready);
  modport sink (input valid, input cmd, input byte_req, output ready);
endinterface

interface xpmd_out_if import xpmd_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [DimW-1:0]   x_pos;
  logic [DimW-1:0]   y_pos;
  logic [ColorW-1:0] color;
  logic [2:0]        error_code;

  modport source (output valid, output kind, output x_pos, output y_pos, output color,
                  output error_code, input ready);
  modport sink (input valid, input kind, input x_pos, input y_pos, input color,
                input error_code, output ready);
endinterface

/* hdl/xpmd_search.sv */
module xpmd_search import xpmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tbl_wr_t   wr_i,
  input  srch_req_t req_i,
  output srch_rsp_t rsp_o
);

  logic [KeyW+ColorW-1:0] mem [MaxColors];
  logic [KeyW+ColorW-1:0] rdata_q;
  srch_e                  st_q, st_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [KeyW-1:0]        key_q;
  logic [CntW-1:0]        cnt_q;
  logic                   hit;
  logic                   last;
  logic [CntW:0]          idx_inc;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= {wr_i.key, wr_i.color};
    end
    rdata_q <= mem[idx_q[AddrW-1:0]];
  end

  assign hit     = (rdata_q[KeyW+ColorW-1:ColorW] == key_q);
  assign idx_inc = {1'b0, idx_q} + 1'b1;
  assign last    = (idx_inc >= {1'b0, cnt_q});

  // next state
  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    case (st_q)
      SR_IDLE: begin
        if (req_i.start) begin
          st_d  = SR_READ;
          idx_d = '0;
        end
      end
      SR_READ: st_d = SR_CMP;
      SR_CMP: begin
        if (hit || last) begin
          st_d = SR_IDLE;
        end else begin
          st_d  = SR_READ;
          idx_d = idx_inc[CntW-1:0];
        end
      end
      default: st_d = SR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp_o.done  = (st_q == SR_CMP) && (hit || last);
    rsp_o.color = hit ? rdata_q[ColorW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= SR_IDLE;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && st_q == SR_IDLE) begin
      key_q <= req_i.key;
      cnt_q <= req_i.count;
    end
  end

endmodule

/* hdl/xpm_text_image_decoder.sv */
// xpm text image decoder: takes xpm text one word at a time (a character, a line end or
// the end of the data), parses the decimal header, stores each color line's key and
// #RRGGBB color in a 256-entry table, and then emits one pixel word per key of each row,
// followed by an image-complete word or an error word. a key that completes a pixel
// starts a linear search of the color table through one shared compare unit, a table
// read and then a compare per stored entry, stopping at the first matching entry or
// after the last stored one; no new word is taken until the search ends. pixels are
// sent before the row's length is known, so a short-row error means the whole image
// must be discarded downstream.
module xpm_text_image_decoder import xpmd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  xpmd_in_if.sink    in_i,
  xpmd_out_if.source out_o
);

  // parser state
  phase_e            phase_q, phase_d;
  logic [DimW-1:0]   iw_q, iw_d, ih_q, ih_d, cc_q, cc_d;
  logic [KlenW-1:0]  kl_q, kl_d;
  logic [DimW-1:0]   line_q, line_d, col_q, col_d;
  logic [KlenW-1:0]  cik_q, cik_d;
  logic [KeyW-1:0]   key_q, key_d;
  hdr_state_e        hs_q, hs_d;
  col_state_e        cs_q, cs_d;
  logic [31:0]       acc_q, acc_d;
  logic [TchW-1:0]   tch_q, tch_d;
  logic              tnone_q, tnone_d, thex_q, thex_d;

  // pending pixel coordinates while the search runs
  logic [DimW-1:0]   px_x_q, px_x_d, px_y_q, px_y_d;

  // sequencer
  seq_e              seq_q, seq_d;

  // output register
  logic              ov_q, ov_d;
  kind_e             okind_q, okind_d;
  logic [DimW-1:0]   ox_q, ox_d, oy_q, oy_d;
  logic [ColorW-1:0] ocol_q, ocol_d;
  err_e              oerr_q, oerr_d;

  tbl_wr_t           wr;
  srch_req_t         req;
  srch_rsp_t         rsp;

  logic              in_acc;
  logic [7:0]        c;
  cmd_e              cmd;

  xpmd_search u_search (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .wr_i  (wr),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign in_acc = in_i.valid && in_i.ready;
  assign c      = in_i.byte_req;
  assign cmd    = cmd_e'(in_i.cmd);

  // sequencer next state
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SQ_IDLE:   if (req.start) seq_d = SQ_SEARCH;
      SQ_SEARCH: if (rsp.done) seq_d = SQ_IDLE;
      default:   seq_d = SQ_IDLE;
    endcase
  end

  // sequencer outputs: take a word only when no search runs and the output register frees up
  always_comb begin
    in_i.ready = (seq_q == SQ_IDLE) && (!ov_q || out_o.ready);
  end

  // per-word datapath
  always_comb begin
    logic             emit;
    logic             clr;
    logic             dig;
    logic [3:0]       dv;
    logic [35:0]      prod;
    logic [31:0]      v;
    logic [4:0]       hv;
    logic             add_tok;
    logic [KlenW:0]   cik_inc;
    logic [DimW:0]    line_inc;
    logic [ColorW-1:0] ccolor;

    emit     = 1'b0;
    clr      = 1'b0;
    dig      = (c >= 8'h30) && (c <= 8'h39);
    dv       = c[3:0];
    prod     = '0;
    v        = '0;
    hv       = hex_val(c);
    add_tok  = 1'b0;
    cik_inc  = {1'b0, cik_q} + 1'b1;
    line_inc = {1'b0, line_q} + 1'b1;
    ccolor   = '0;

    phase_d = phase_q;
    iw_d    = iw_q;
    ih_d    = ih_q;
    cc_d    = cc_q;
    kl_d    = kl_q;
    line_d  = line_q;
    col_d   = col_q;
    cik_d   = cik_q;
    key_d   = key_q;
    hs_d    = hs_q;
    cs_d    = cs_q;
    acc_d   = acc_q;
    tch_d   = tch_q;
    tnone_d = tnone_q;
    thex_d  = thex_q;
    px_x_d  = px_x_q;
    px_y_d  = px_y_q;

    okind_d = okind_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    ocol_d  = ocol_q;
    oerr_d  = oerr_q;

    wr.we    = 1'b0;
    wr.addr  = line_q[AddrW-1:0];
    wr.key   = key_q;
    wr.color = '0;
    req.start = 1'b0;
    req.key   = {key_q[KeyW-9:0], c};
    req.count = cc_q[CntW-1:0];

    if (in_acc) begin
      case (cmd)
        CMD_EOD: begin
          if (phase_q != PH_WAIT) begin
            emit = 1'b1;
            okind_d = KIND_ERROR;
            oerr_d  = ERR_EARLY_END;
          end
          phase_d = PH_HEADER;
          line_d  = '0;
          clr     = 1'b1;
        end
        CMD_CHAR, CMD_EOL: begin
          case (phase_q)
            PH_HEADER: begin
              if (cmd == CMD_CHAR && (hs_q == HS_DIGP || hs_q == HS_DIGN) && dig) begin
                // accumulate acc*10 + digit, saturating
                prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, dv};
                acc_d = (prod > {4'b0, NumCap}) ? NumCap : prod[31:0];
              end else begin
                if (hs_q == HS_DIGP || hs_q == HS_DIGN) begin
                  // a digit run ends: store the number in the next header slot
                  v = (hs_q == HS_DIGN) ? 32'd0 : acc_q;
                  case (tch_q[1:0])
                    2'd0: iw_d = (v > 32'h1fff) ? 13'h1fff : v[DimW-1:0];
                    2'd1: ih_d = (v > 32'h1fff) ? 13'h1fff : v[DimW-1:0];
                    2'd2: cc_d = (v > 32'h1fff) ? 13'h1fff : v[DimW-1:0];
                    default: kl_d = (v > 32'hf) ? 4'hf : v[KlenW-1:0];
                  endcase
                  tch_d = tch_q + 1'b1;
                  acc_d = '0;
                  hs_d  = (tch_q[1:0] == 2'd3) ? HS_DONE : HS_SKIP;
                end
                if (cmd == CMD_CHAR) begin
                  if (hs_d == HS_SKIP) begin
                    if (!is_ws(c)) begin
                      if (c == 8'h2b) hs_d = HS_SIGNP;
                      else if (c == 8'h2d) hs_d = HS_SIGNN;
                      else if (dig) begin
                        hs_d  = HS_DIGP;
                        acc_d = {28'b0, dv};
                      end else hs_d = HS_FAIL;
                    end
                  end else if (hs_d == HS_SIGNP || hs_d == HS_SIGNN) begin
                    if (dig) begin
                      hs_d  = (hs_d == HS_SIGNP) ? HS_DIGP : HS_DIGN;
                      acc_d = {28'b0, dv};
                    end else hs_d = HS_FAIL;
                  end
                end else begin
                  // header line end: validate
                  emit = 1'b1;
                  if (hs_d != HS_DONE || iw_d == '0 || ih_d == '0 || cc_d == '0 ||
                      kl_d == '0) begin
                    okind_d = KIND_ERROR;
                    oerr_d  = ERR_HEADER;
                    phase_d = PH_WAIT;
                  end else if (iw_d > DimW'(MaxWidth) || ih_d > DimW'(MaxHeight) ||
                               cc_d > DimW'(MaxColors) || kl_d > KlenW'(MaxKeyChars)) begin
                    okind_d = KIND_ERROR;
                    oerr_d  = ERR_OVERSIZE;
                    phase_d = PH_WAIT;
                  end else begin
                    okind_d = KIND_HEADER;
                    ox_d    = iw_d;
                    oy_d    = ih_d;
                    phase_d = PH_COLORS;
                    line_d  = '0;
                    clr     = 1'b1;
                  end
                end
              end
            end
            PH_COLORS: begin
              if (cmd == CMD_CHAR) begin
                case (cs_q)
                  CS_KEY: begin
                    key_d = {key_q[KeyW-9:0], c};
                    cik_d = cik_inc[KlenW-1:0];
                    if (cik_inc >= {1'b0, kl_q}) cs_d = CS_SEEK;
                  end
                  CS_SEEK: if (!is_ws(c)) cs_d = (c == 8'h63) ? CS_CAND : CS_SKIP;
                  CS_SKIP: if (is_ws(c)) cs_d = CS_SEEK;
                  CS_CAND: cs_d = is_ws(c) ? CS_AFTER : CS_SKIP;
                  CS_AFTER: begin
                    if (!is_ws(c)) begin
                      tch_d   = '0;
                      acc_d   = '0;
                      tnone_d = 1'b1;
                      thex_d  = 1'b1;
                      add_tok = 1'b1;
                      cs_d    = CS_TOK;
                    end
                  end
                  CS_TOK: begin
                    if (is_ws(c)) cs_d = CS_REST;
                    else add_tok = 1'b1;
                  end
                  default: ;
                endcase
                if (add_tok) begin
                  if (tch_d < 7'd4 && c != none_char(tch_d[1:0])) tnone_d = 1'b0;
                  if (tch_d == 7'd0 && c != 8'h23) thex_d = 1'b0;
                  if (tch_d >= 7'd1 && tch_d <= 7'd6) begin
                    if (!hv[4]) thex_d = 1'b0;
                    else acc_d = {8'b0, acc_d[19:0], hv[3:0]};
                  end
                  if (tch_d < 7'd127) tch_d = tch_d + 1'b1;
                end
              end else begin
                // color line end
                if (cs_q == CS_KEY) begin
                  emit    = 1'b1;
                  okind_d = KIND_ERROR;
                  oerr_d  = ERR_SHORT_COLOR;
                  phase_d = PH_WAIT;
                end else if ((cs_q == CS_TOK || cs_q == CS_REST) &&
                             !(tch_q == 7'd4 && tnone_q) && !(tch_q == 7'd7 && thex_q)) begin
                  emit    = 1'b1;
                  okind_d = KIND_ERROR;
                  oerr_d  = ERR_COLOR_SPEC;
                  phase_d = PH_WAIT;
                end else begin
                  if ((cs_q == CS_TOK || cs_q == CS_REST) && !(tch_q == 7'd4 && tnone_q)) begin
                    ccolor = acc_q[ColorW-1:0];
                  end
                  wr.we    = 1'b1;
                  wr.color = ccolor;
                  clr      = 1'b1;
                  if (line_inc >= {1'b0, cc_q}) begin
                    phase_d = PH_PIXELS;
                    line_d  = '0;
                  end else begin
                    line_d = line_inc[DimW-1:0];
                  end
                end
              end
            end
            PH_PIXELS: begin
              if (cmd == CMD_CHAR) begin
                // characters past the row width are dropped
                if (col_q < iw_q) begin
                  key_d = {key_q[KeyW-9:0], c};
                  cik_d = cik_inc[KlenW-1:0];
                  if (cik_inc >= {1'b0, kl_q}) begin
                    req.start = 1'b1;
                    px_x_d    = col_q;
                    px_y_d    = line_q;
                    col_d     = col_q + 1'b1;
                    cik_d     = '0;
                    key_d     = '0;
                  end
                end
              end else begin
                emit = 1'b1;
                if (col_q < iw_q) begin
                  okind_d = KIND_ERROR;
                  oerr_d  = ERR_SHORT_ROW;
                  phase_d = PH_WAIT;
                end else begin
                  clr = 1'b1;
                  if (line_inc >= {1'b0, ih_q}) begin
                    okind_d = KIND_DONE;
                    phase_d = PH_WAIT;
                    line_d  = line_inc[DimW-1:0];
                  end else begin
                    emit   = 1'b0;
                    line_d = line_inc[DimW-1:0];
                  end
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // search finished: send the pending pixel
    if (rsp.done) begin
      emit    = 1'b1;
      okind_d = KIND_PIXEL;
      ox_d    = px_x_q;
      oy_d    = px_y_q;
      ocol_d  = rsp.color;
    end

    if (emit) begin
      if (okind_d != KIND_HEADER && okind_d != KIND_PIXEL) begin
        ox_d = '0;
        oy_d = '0;
      end
      if (okind_d != KIND_PIXEL) ocol_d = '0;
      if (okind_d != KIND_ERROR) oerr_d = ERR_HEADER;
    end

    ov_d = emit || (ov_q && !out_o.ready);

    if (clr) begin
      cik_d   = '0;
      key_d   = '0;
      hs_d    = HS_SKIP;
      cs_d    = CS_KEY;
      acc_d   = '0;
      tch_d   = '0;
      col_d   = '0;
      tnone_d = 1'b0;
      thex_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      iw_q    <= '0;
      ih_q    <= '0;
      cc_q    <= '0;
      kl_q    <= '0;
      line_q  <= '0;
      col_q   <= '0;
      cik_q   <= '0;
      key_q   <= '0;
      hs_q    <= HS_SKIP;
      cs_q    <= CS_KEY;
      acc_q   <= '0;
      tch_q   <= '0;
      tnone_q <= 1'b0;
      thex_q  <= 1'b0;
      seq_q   <= SQ_IDLE;
      ov_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      iw_q    <= iw_d;
      ih_q    <= ih_d;
      cc_q    <= cc_d;
      kl_q    <= kl_d;
      line_q  <= line_d;
      col_q   <= col_d;
      cik_q   <= cik_d;
      key_q   <= key_d;
      hs_q    <= hs_d;
      cs_q    <= cs_d;
      acc_q   <= acc_d;
      tch_q   <= tch_d;
      tnone_q <= tnone_d;
      thex_q  <= thex_d;
      seq_q   <= seq_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    px_x_q  <= px_x_d;
    px_y_q  <= px_y_d;
    okind_q <= okind_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    ocol_q  <= ocol_d;
    oerr_q  <= oerr_d;
  end

  assign out_o.valid      = ov_q;
  assign out_o.kind       = okind_q;
  assign out_o.x_pos      = ox_q;
  assign out_o.y_pos      = oy_q;
  assign out_o.color      = ocol_q;
  assign out_o.error_code = oerr_q;

  // a search result only appears while the sequencer waits for it
  a_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> seq_q == SQ_SEARCH)
    else $error("search result outside a search");

  // a pixel word is only pending while pixel rows are being parsed
  a_pixel_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && okind_q == KIND_PIXEL) |-> phase_q == PH_PIXELS)
    else $error("pixel word outside pixel phase");

  // the column counter never runs past the image width
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PIXELS |-> col_q <= iw_q)
    else $error("column past image width");

endmodule

/* tb/sv/tb_xpm_text_image_decoder.sv */
module tb_xpm_text_image_decoder;
  import xpmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2_000_000;
  localparam int TextItems  = 1550;
  localparam int DrainWait  = 2 * MaxColors + 100;

  // one decoded output word
  typedef struct packed {
    logic [1:0]        kind;
    logic [DimW-1:0]   x;
    logic [DimW-1:0]   y;
    logic [ColorW-1:0] color;
    logic [2:0]        err;
  } word_t;

  // one text item; hold means wait for every expected word first
  typedef struct {
    logic [1:0] cmd;
    logic [7:0] ch;
    bit         hold;
  } text_t;

  logic clk_i;
  logic rst_ni;

  xpmd_in_if  in_if ();
  xpmd_out_if out_if ();

  xpm_text_image_decoder DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  text_t text_pending[$];
  word_t words_due[$];
  int    fails;
  int    words_seen;
  int    items_queued;
  int    cycles;
  bit    in_took;
  bit    out_took;

  // ---------------------------------------------------------------
  // decoder shadow state
  // ---------------------------------------------------------------
  logic [KeyW-1:0]   key_mem[MaxColors];
  logic [ColorW-1:0] color_mem[MaxColors];
  phase_e            ph;
  int unsigned       img_w, img_h, n_colors, key_len;
  int unsigned       line_no, col_no, key_pos, tok_len;
  logic [KeyW-1:0]   key_acc;
  logic [2:0]        tstate;   // header or color line sub-state
  logic [31:0]       num_acc;
  bit                tok_none, tok_hex;
  string             none_str = "None";

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int hexv(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic word_t mk(kind_e k, int unsigned x, int unsigned y,
                               logic [ColorW-1:0] c, err_e e);
    word_t r;
    r.kind  = k;
    r.x     = x[DimW-1:0];
    r.y     = y[DimW-1:0];
    r.color = c;
    r.err   = e;
    return r;
  endfunction

  function automatic word_t fail_word(err_e e);
    ph = PH_WAIT;
    return mk(KIND_ERROR, 0, 0, 0, e);
  endfunction

  function automatic void clear_line();
    key_pos  = 0;
    key_acc  = '0;
    tstate   = HS_SKIP;
    num_acc  = '0;
    tok_len  = 0;
    col_no   = 0;
    tok_none = 0;
    tok_hex  = 0;
  endfunction

  function automatic void reset_model();
    ph       = PH_HEADER;
    img_w    = 0;
    img_h    = 0;
    n_colors = 0;
    key_len  = 0;
    line_no  = 0;
    clear_line();
  endfunction

  // close one header number; tok_len counts numbers here
  function automatic void hdr_store();
    int unsigned v;
    v = (tstate == HS_DIGN) ? 0 : num_acc;
    case (tok_len)
      0: img_w = v;
      1: img_h = v;
      2: n_colors = v;
      default: key_len = v;
    endcase
    tok_len++;
    num_acc = '0;
    tstate  = (tok_len >= 4) ? HS_DONE : HS_SKIP;
  endfunction

  function automatic void hdr_char(logic [7:0] c);
    longint a;
    if (tstate == HS_DIGP || tstate == HS_DIGN) begin
      if (is_dec(c)) begin
        a = longint'(num_acc) * 10 + longint'(c - "0");
        num_acc = (a > longint'(NumCap)) ? NumCap : a[31:0];
        return;
      end
      hdr_store();
    end
    if (tstate == HS_SKIP) begin
      if (is_space(c)) return;
      if (c == "+") tstate = HS_SIGNP;
      else if (c == "-") tstate = HS_SIGNN;
      else if (is_dec(c)) begin
        tstate  = HS_DIGP;
        num_acc = 32'(c - "0");
      end else tstate = HS_FAIL;
    end else if (tstate == HS_SIGNP || tstate == HS_SIGNN) begin
      if (is_dec(c)) begin
        tstate  = (tstate == HS_SIGNP) ? HS_DIGP : HS_DIGN;
        num_acc = 32'(c - "0");
      end else tstate = HS_FAIL;
    end
  endfunction

  function automatic void tok_add(logic [7:0] c);
    int d;
    if (tok_len < 4 && c != none_str[tok_len]) tok_none = 0;
    if (tok_len == 0 && c != "#") tok_hex = 0;
    if (tok_len >= 1 && tok_len <= 6) begin
      d = hexv(c);
      if (d < 0) tok_hex = 0;
      else num_acc = ((num_acc << 4) | d) & 32'h00ff_ffff;
    end
    if (tok_len < 127) tok_len++;
  endfunction

  function automatic void color_char(logic [7:0] c);
    case (tstate)
      CS_KEY: begin
        key_acc = {key_acc[KeyW-9:0], c};
        key_pos++;
        if (key_pos >= key_len) tstate = CS_SEEK;
      end
      CS_SEEK:  if (!is_space(c)) tstate = (c == "c") ? CS_CAND : CS_SKIP;
      CS_SKIP:  if (is_space(c)) tstate = CS_SEEK;
      CS_CAND:  tstate = is_space(c) ? CS_AFTER : CS_SKIP;
      CS_AFTER: if (!is_space(c)) begin
        tok_len  = 0;
        num_acc  = '0;
        tok_none = 1;
        tok_hex  = 1;
        tok_add(c);
        tstate   = CS_TOK;
      end
      CS_TOK: if (is_space(c)) tstate = CS_REST; else tok_add(c);
      default: ;
    endcase
  endfunction

  // advance the shadow decoder by one text word; returns 1 when a word is due
  function automatic bit decode_word(logic [1:0] cmd, logic [7:0] c, output word_t r);
    phase_e            was;
    logic [ColorW-1:0] col;
    r = '0;
    if (cmd == CMD_NOP) return 0;
    if (cmd == CMD_EOD) begin
      was     = ph;
      ph      = PH_HEADER;
      line_no = 0;
      clear_line();
      if (was != PH_WAIT) begin
        r = mk(KIND_ERROR, 0, 0, 0, ERR_EARLY_END);
        return 1;
      end
      return 0;
    end
    case (ph)
      PH_HEADER: begin
        if (cmd == CMD_CHAR) begin
          hdr_char(c);
          return 0;
        end
        if (tstate == HS_DIGP || tstate == HS_DIGN) hdr_store();
        if (tstate != HS_DONE || img_w == 0 || img_h == 0 || n_colors == 0 || key_len == 0)
          r = fail_word(ERR_HEADER);
        else if (img_w > MaxWidth || img_h > MaxHeight || n_colors > MaxColors ||
                 key_len > MaxKeyChars)
          r = fail_word(ERR_OVERSIZE);
        else begin
          ph      = PH_COLORS;
          line_no = 0;
          clear_line();
          r = mk(KIND_HEADER, img_w, img_h, 0, ERR_HEADER);
        end
        return 1;
      end
      PH_COLORS: begin
        if (cmd == CMD_CHAR) begin
          color_char(c);
          return 0;
        end
        col = '0;
        if (tstate == CS_KEY) begin
          r = fail_word(ERR_SHORT_COLOR);
          return 1;
        end
        if (tstate == CS_TOK || tstate == CS_REST) begin
          if (tok_len == 4 && tok_none) col = '0;
          else if (tok_len == 7 && tok_hex) col = num_acc[ColorW-1:0];
          else begin
            r = fail_word(ERR_COLOR_SPEC);
            return 1;
          end
        end
        if (line_no < MaxColors) begin
          key_mem[line_no]   = key_acc;
          color_mem[line_no] = col;
        end
        line_no++;
        clear_line();
        if (line_no >= n_colors) begin
          ph      = PH_PIXELS;
          line_no = 0;
        end
        return 0;
      end
      PH_PIXELS: begin
        if (cmd == CMD_CHAR) begin
          if (col_no >= img_w) return 0;
          key_acc = {key_acc[KeyW-9:0], c};
          key_pos++;
          if (key_pos < key_len) return 0;
          col = '0;
          // first matching key wins
          for (int i = 0; i < n_colors && i < MaxColors; i++)
            if (key_mem[i] == key_acc) begin
              col = color_mem[i];
              break;
            end
          r = mk(KIND_PIXEL, col_no, line_no, col, ERR_HEADER);
          col_no++;
          key_pos = 0;
          key_acc = '0;
          return 1;
        end
        if (col_no < img_w) begin
          r = fail_word(ERR_SHORT_ROW);
          return 1;
        end
        line_no++;
        clear_line();
        if (line_no >= img_h) begin
          ph = PH_WAIT;
          r = mk(KIND_DONE, 0, 0, 0, ERR_HEADER);
          return 1;
        end
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------
  // text builders
  // ---------------------------------------------------------------
  function automatic void put(cmd_e cmd, logic [7:0] ch);
    text_t t;
    t.cmd  = cmd;
    t.ch   = ch;
    t.hold = 0;
    text_pending.push_back(t);
    if (cmd != CMD_NOP) items_queued++;
    // occasional no-op noise
    if ($urandom_range(0, 49) == 0) begin
      t.cmd = CMD_NOP;
      t.ch  = rand_byte();
      text_pending.push_back(t);
    end
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(CMD_CHAR, s[i]);
  endfunction

  function automatic void put_hold();
    text_t t;
    t.cmd  = CMD_NOP;
    t.ch   = 8'h00;
    t.hold = 1;
    text_pending.push_back(t);
  endfunction

  function automatic void put_key(logic [KeyW-1:0] k, int len);
    for (int b = len - 1; b >= 0; b--) put(CMD_CHAR, k[8*b+:8]);
  endfunction

  // #RRGGBB with random letter case
  function automatic void put_hex(logic [23:0] v);
    logic [3:0] n;
    put(CMD_CHAR, "#");
    for (int d = 5; d >= 0; d--) begin
      n = v[4*d+:4];
      if (n < 10) put(CMD_CHAR, "0" + n);
      else put(CMD_CHAR, 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10));
    end
  endfunction

  function automatic void put_gap();
    int n;
    n = $urandom_range(1, 2);
    for (int i = 0; i < n; i++) put(CMD_CHAR, $urandom_range(0, 1) ? " " : 8'h09);
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom()};
  endfunction

  // one image, mostly well formed, with rare defects
  function automatic void gen_image();
    string             bad_hdr[10];
    logic [KeyW-1:0]   keys[$];
    logic [KeyW-1:0]   k;
    int                kl, wd, ht, nc, flavor, bad_line, pick, cols;
    bad_hdr = '{"4 3 2", "-3 2 1 1", "0 2 1 1", "4 x 1 1", "4097 1 1 1",
                "1 4097 1 1", "2 2 257 1", "2 2 2 5", "+ 2 2 2 2", "99999999999 1 1 1"};
    kl     = $urandom_range(1, MaxKeyChars);
    wd     = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    ht     = $urandom_range(1, 4);
    nc     = $urandom_range(1, 6);
    flavor = $urandom_range(0, 99);

    // header, bad in a few cases
    if (flavor < 8) begin
      put_str(bad_hdr[$urandom_range(0, 9)]);
      put(CMD_EOL, rand_byte());
      if ($urandom_range(0, 1)) put_str("x 1\n");
      put(CMD_EOD, rand_byte());
      return;
    end
    if ($urandom_range(0, 3) == 0) put_gap();
    put_str($sformatf("%s%0d", $urandom_range(0, 3) == 0 ? "+" : "", wd));
    put_gap();
    put_str($sformatf("%0d", ht));
    put_gap();
    put_str($sformatf("%s%0d", $urandom_range(0, 3) == 0 ? "+" : "", nc));
    put_gap();
    put_str($sformatf("%0d", kl));
    if ($urandom_range(0, 4) == 0) put_str(" 7 xyz");
    put(CMD_EOL, rand_byte());

    // color lines; a bad line in some images
    bad_line = (flavor < 16) ? $urandom_range(0, nc - 1) : -1;
    for (int i = 0; i < nc; i++) begin
      k = rand_key();
      // repeated key: first stored one wins
      if (i > 0 && $urandom_range(0, 7) == 0) k = keys[$urandom_range(0, keys.size() - 1)];
      k = k & KeyW'((64'h1 << (8 * kl)) - 1);
      keys.push_back(k);
      if (i == bad_line) begin
        pick = $urandom_range(0, 3);
        if (pick == 0 && kl > 1) put_key(k, kl - 1);
        else begin
          put_key(k, kl);
          case (pick)
            1: put_str(" c #12345");
            2: put_str(" c #12g456");
            default: put_str(" c Nonex");
          endcase
        end
        put(CMD_EOL, rand_byte());
        put(CMD_EOD, rand_byte());
        return;
      end
      put_key(k, kl);
      case ($urandom_range(0, 19))
        0: put_str(" c None");
        1: ;
        2: put_str(" c");
        3: begin
          put_str(" m ");
          put_hex(24'($urandom()));
          put_str(" c ");
          put_hex(24'($urandom()));
        end
        4: put_str(" cx #123456");
        5: begin
          put_str("\tc\t");
          put_hex(24'($urandom()));
          put_str("  s tag");
        end
        default: begin
          put_str(" c ");
          put_hex(24'($urandom()));
        end
      endcase
      put(CMD_EOL, rand_byte());
    end

    // early end right after the colors
    if (flavor < 20) begin
      put(CMD_EOD, rand_byte());
      return;
    end

    // pixel rows
    for (int j = 0; j < ht; j++) begin
      cols = (flavor < 25 && j == ht - 1) ? $urandom_range(0, wd - 1) : wd;
      for (int i = 0; i < cols; i++) begin
        if ($urandom_range(0, 6) == 0) k = rand_key();
        else k = keys[$urandom_range(0, keys.size() - 1)];
        put_key(k, kl);
      end
      // characters past the row width are dropped
      if (cols == wd && $urandom_range(0, 5) == 0) put_str("zz");
      put(CMD_EOL, rand_byte());
    end
    if ($urandom_range(0, 4) == 0) put_str("trailing\n");
    put(CMD_EOD, rand_byte());
  endfunction

  // ---------------------------------------------------------------
  // clock, reset, watchdog
  // ---------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // text word driver: changes at the falling edge
  // ---------------------------------------------------------------
  int gap_left;
  bit tx_burst;

  always @(negedge clk_i) begin : drive_text
    text_t t;
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.cmd      <= CMD_NOP;
      in_if.byte_req <= 8'h00;
      gap_left       <= 0;
    end else if (!in_if.valid || in_took) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (text_pending.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (text_pending[0].hold) begin
        // pause until every expected word has come out
        in_if.valid <= 1'b0;
        if (words_due.size() == 0) void'(text_pending.pop_front());
      end else begin
        t = text_pending.pop_front();
        in_if.valid    <= 1'b1;
        in_if.cmd      <= t.cmd;
        in_if.byte_req <= t.ch;
        if ($urandom_range(0, 149) == 0) tx_burst = !tx_burst;
        gap_left <= tx_burst ? 0 : $urandom_range(0, 11);
      end
    end
  end

  // ---------------------------------------------------------------
  // result receiver: ready with random stalls and one long hold
  // ---------------------------------------------------------------
  int stall_left;
  bit rx_burst;

  always @(negedge clk_i) begin : drive_ready
    int n;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_took) begin
      if ($urandom_range(0, 149) == 0) rx_burst = !rx_burst;
      // long hold once so the decoder backs up into its input
      n = (words_seen == 200) ? 700 : (rx_burst ? 0 : $urandom_range(0, 11));
      out_if.ready <= (n == 0);
      stall_left   <= n;
    end else if (stall_left > 0) begin
      out_if.ready <= (stall_left == 1);
      stall_left   <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // monitor: predict on accepted text, check accepted results
  // ---------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    word_t want;
    bit    due;
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (in_if.valid && in_if.ready) begin
        due = decode_word(in_if.cmd, in_if.byte_req, want);
        if (due) words_due.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        words_seen++;
        if (words_due.size() == 0) begin
          $error("unexpected result word: kind %0d", out_if.kind);
          fails++;
        end else begin
          want = words_due.pop_front();
          if ($isunknown({out_if.kind, out_if.x_pos, out_if.y_pos, out_if.color,
                          out_if.error_code})) begin
            $error("result word has unknown bits");
            fails++;
          end
          check_field("kind", want.kind, out_if.kind);
          check_field("x_pos", want.x, out_if.x_pos);
          check_field("y_pos", want.y, out_if.y_pos);
          check_field("color", want.color, out_if.color);
          check_field("error_code", want.err, out_if.error_code);
        end
      end
    end
    in_took  <= rst_ni && in_if.valid && in_if.ready;
    out_took <= rst_ni && out_if.valid && out_if.ready;
  end

  // ---------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;

    // directed: end with no data, ignored no-op, oversize, largest legal header
    put(CMD_EOD, 8'h00);
    put(CMD_NOP, 8'hff);
    put_str("4097 1 1 1");
    put(CMD_EOL, 8'h00);
    put(CMD_EOD, 8'h00);
    put_str("4096 4096 256 4");
    put(CMD_EOL, 8'h00);
    put(CMD_EOD, 8'h00);
    // one pixel keyed by a zero byte, mixed-case hex color
    put_str("1 1 1 1");
    put(CMD_EOL, 8'h00);
    put(CMD_CHAR, 8'h00);
    put_str(" c #aB09fF");
    put(CMD_EOL, 8'h00);
    put(CMD_CHAR, 8'h00);
    put(CMD_EOL, 8'h00);
    put(CMD_EOD, 8'hff);
    put_hold();

    // random images, with a full drain every few
    for (int n = 0; items_queued < TextItems; n++) begin
      gen_image();
      if (n % 8 == 7) put_hold();
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_pending.size() != 0 || in_if.valid) @(posedge clk_i);
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (fails == 0 && words_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
